FILE: design/bucketed_cuckoo_hash_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bucketed cuckoo hash table unit
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUCKETED_CUCKOO_HASH_TABLE_UNIT_DEFINES_SVH
`define BUCKETED_CUCKOO_HASH_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define BCHT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcht assertion failed");

// next-cycle implication
`define BCHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcht assertion failed");

`endif

FILE: design/bcht_pkg.sv
// ----------------------------------------------------------------------------
// bcht_pkg
// Types, constants and codes shared by the hash table unit modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bcht_pkg;

  // table geometry
  localparam int TABLE_BITS = 10;
  localparam int SLOT_W     = TABLE_BITS;
  localparam int GROUP_BITS = TABLE_BITS - 2;
  localparam int ROWS       = 1 << GROUP_BITS;
  localparam int CNT_W      = TABLE_BITS + 1;

  // register reset values
  localparam logic [63:0] FIRST_MULT_RST  = 64'h9e3779b99e3779bd;
  localparam logic [63:0] SECOND_MULT_RST = 64'h61c8eb8961c8865f;
  localparam logic [7:0]  MAX_TRIES_RST   = 8'd100;

  // configuration register indexes
  localparam logic [1:0] CFG_FIRST_MULT  = 2'd0;
  localparam logic [1:0] CFG_SECOND_MULT = 2'd1;
  localparam logic [1:0] CFG_MAX_TRIES   = 2'd2;

  // opcodes
  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_SET    = 3'd3;
  localparam logic [2:0] OP_GET    = 3'd4;

  // result status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_MISS     = 2'd1;
  localparam logic [1:0] STS_FAIL     = 2'd2;
  localparam logic [1:0] STS_ZERO_KEY = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] key;
    logic [9:0]  slot_index;
    logic [63:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  result_slot;
    logic [63:0] read_value;
    logic [63:0] ejected_key;
    logic [63:0] ejected_value;
    logic [10:0] stored_count;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_H1, ST_H1W, ST_H2, ST_H2W,
    ST_RD1, ST_RD2, ST_CMP, ST_DEL_WR, ST_EV_CHK, ST_EV_H, ST_EV_HW,
    ST_EV_RD, ST_EV_WR, ST_IDX_RD, ST_IDX_OP, ST_RESULT
  } state_t;

  typedef enum logic [2:0] {
    RES_ZERO_KEY, RES_UNUSED, RES_FIND, RES_IDX, RES_INS_OK, RES_INS_FAIL
  } res_kind_t;

  typedef enum logic [1:0] {
    RD_G1, RD_G2, RD_EV, RD_IDX
  } rd_src_t;

  // controller to datapath
  typedef struct packed {
    logic      load_item;
    logic      clr_step;
    logic      hash_start;
    logic      hash_two;
    logic      hash_pend;
    logic      save_g1;
    logic      save_g2;
    logic      save_ev;
    logic      rd_en;
    rd_src_t   rd_src;
    logic      cap_a;
    logic      cap_find;
    logic      ev_init;
    logic      ev_write;
    logic      del_write;
    logic      set_write;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      res_load;
    res_kind_t res_kind;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       clr_last;
    logic       hash_done;
    logic       found;
    logic [2:0] op;
    logic       key_zero;
    logic       tries_done;
    logic       ev_odd;
    logic       ev_empty;
    logic       ev_next_zero;
    logic       out_busy;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/bcht_hash.sv
// ----------------------------------------------------------------------------
// bcht_hash
// Multicycle multiplicative hash: low 64 bits of multiplier * key built from
// three 32x32 partial products on one shared multiplier, top bits -> group.
// ----------------------------------------------------------------------------
`default_nettype none

module bcht_hash
  import bcht_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [63:0]           mult,
  input  wire logic [63:0]           key,
  output logic                       done,
  output logic [GROUP_BITS-1:0]      group
);

  logic [2:0]  ph_r, ph_nxt;
  logic [63:0] a_r, b_r;
  logic [63:0] prod_r;
  logic [31:0] lohi_r, acc_r, sum_r;
  logic [31:0] mul_a, mul_b;

  // phase counter: 1..3 multiply, 4 sum, 5 done
  always_comb begin
    ph_nxt = ph_r;
    if (start) begin
      ph_nxt = 3'd1;
    end else if (ph_r == 3'd5) begin
      ph_nxt = 3'd0;
    end else if (ph_r != 3'd0) begin
      ph_nxt = ph_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= 3'd0;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  // operand halves per phase
  assign mul_a = (ph_r == 3'd2) ? a_r[63:32] : a_r[31:0];
  assign mul_b = (ph_r == 3'd3) ? b_r[63:32] : b_r[31:0];

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= mult;
      b_r <= key;
    end
    prod_r <= mul_a * mul_b;
    if (ph_r == 3'd2) lohi_r <= prod_r[63:32];
    if (ph_r == 3'd3) acc_r  <= prod_r[31:0];
    if (ph_r == 3'd4) sum_r  <= lohi_r + acc_r + prod_r[31:0];
  end

  assign done  = (ph_r == 3'd5);
  assign group = sum_r[31 -: GROUP_BITS];

endmodule

`default_nettype wire

FILE: design/bcht_datapath.sv
// ----------------------------------------------------------------------------
// bcht_datapath
// Key and value stores (rows of four slots), hash unit, eviction registers,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bcht_datapath
  import bcht_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire in_item_t    in_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data
);

  // stores
  logic [63:0] key_mem [ROWS][4];
  logic [63:0] val_mem [ROWS][4];

  logic [63:0] rowk_r [4];
  logic [63:0] rowv_r [4];

  logic [63:0] mult1_r, mult2_r;
  logic [7:0]  max_tries_r;

  in_item_t              item_r;
  logic [GROUP_BITS-1:0] g1_r, g2_r, evg_r;
  logic [63:0]           a0_r, a1_r;
  logic                  found_r;
  logic [SLOT_W-1:0]     fslot_r;
  logic [63:0]           pend_k_r, pend_v_r;
  logic [7:0]            t_r;
  logic                  odd_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [GROUP_BITS-1:0] clr_addr_r;
  out_item_t             out_r, out_nxt;
  logic                  out_valid_r;

  logic                  hash_done;
  logic [GROUP_BITS-1:0] hash_group;
  logic [SLOT_W-1:0]     idx_slot;
  logic                  found_now;
  logic [SLOT_W-1:0]     fslot_now;
  logic [63:0]           ev_kx, ev_k2, ev_vx, ev_v2;

  // memory port controls
  logic                  wr_en;
  logic [GROUP_BITS-1:0] wr_row;
  logic [3:0]            key_we, val_we;
  logic [63:0]           key_wd [4];
  logic [63:0]           val_wd [4];
  logic [GROUP_BITS-1:0] rd_row;

  assign idx_slot = SLOT_W'(item_r.slot_index);

  // hash unit
  bcht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.hash_start),
    .mult  (cmd.hash_two ? mult2_r : mult1_r),
    .key   (cmd.hash_pend ? pend_k_r : item_r.key),
    .done  (hash_done),
    .group (hash_group)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult1_r     <= FIRST_MULT_RST;
      mult2_r     <= SECOND_MULT_RST;
      max_tries_r <= MAX_TRIES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_MULT:  mult1_r     <= cfg_wdata;
        CFG_SECOND_MULT: mult2_r     <= cfg_wdata;
        CFG_MAX_TRIES:   max_tries_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // four-slot probe of the held rows
  always_comb begin
    found_now = 1'b1;
    if (a0_r == item_r.key) begin
      fslot_now = {g1_r, 2'd0};
    end else if (a1_r == item_r.key) begin
      fslot_now = {g1_r, 2'd1};
    end else if (rowk_r[2] == item_r.key) begin
      fslot_now = {g2_r, 2'd2};
    end else if (rowk_r[3] == item_r.key) begin
      fslot_now = {g2_r, 2'd3};
    end else begin
      found_now = 1'b0;
      fslot_now = '0;
    end
  end

  // eviction pair of the held row
  assign ev_kx = odd_r ? rowk_r[2] : rowk_r[0];
  assign ev_k2 = odd_r ? rowk_r[3] : rowk_r[1];
  assign ev_vx = odd_r ? rowv_r[2] : rowv_r[0];
  assign ev_v2 = odd_r ? rowv_r[3] : rowv_r[1];

  // write port selection
  always_comb begin
    wr_en  = 1'b0;
    wr_row = clr_addr_r;
    key_we = 4'b0000;
    val_we = 4'b0000;
    for (int j = 0; j < 4; j++) begin
      key_wd[j] = '0;
      val_wd[j] = '0;
    end
    if (cmd.clr_step) begin
      wr_en  = 1'b1;
      key_we = 4'b1111;
      val_we = 4'b1111;
    end else if (cmd.ev_write) begin
      wr_en  = 1'b1;
      wr_row = evg_r;
      key_wd[{odd_r, 1'b0}] = pend_k_r;
      val_wd[{odd_r, 1'b0}] = pend_v_r;
      key_wd[{odd_r, 1'b1}] = ev_kx;
      val_wd[{odd_r, 1'b1}] = ev_vx;
      key_we[{odd_r, 1'b0}] = 1'b1;
      val_we[{odd_r, 1'b0}] = 1'b1;
      if (ev_kx != 64'd0) begin
        key_we[{odd_r, 1'b1}] = 1'b1;
        val_we[{odd_r, 1'b1}] = 1'b1;
      end
    end else if (cmd.del_write) begin
      wr_en  = 1'b1;
      wr_row = fslot_r[SLOT_W-1:2];
      key_we[fslot_r[1:0]] = 1'b1;
      val_we[fslot_r[1:0]] = 1'b1;
    end else if (cmd.set_write) begin
      wr_en  = 1'b1;
      wr_row = idx_slot[SLOT_W-1:2];
      val_wd[idx_slot[1:0]] = item_r.data_value;
      val_we[idx_slot[1:0]] = 1'b1;
    end
  end

  // read row selection
  always_comb begin
    case (cmd.rd_src)
      RD_G1:   rd_row = g1_r;
      RD_G2:   rd_row = g2_r;
      RD_EV:   rd_row = evg_r;
      default: rd_row = idx_slot[SLOT_W-1:2];
    endcase
  end

  // stores: masked write, registered row read
  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      if (wr_en && key_we[j]) key_mem[wr_row][j] <= key_wd[j];
      if (wr_en && val_we[j]) val_mem[wr_row][j] <= val_wd[j];
      if (cmd.rd_en) begin
        rowk_r[j] <= key_mem[rd_row][j];
        rowv_r[j] <= val_mem[rd_row][j];
      end
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // item, hash groups and probe results
  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
    if (cmd.save_g1)   g1_r   <= hash_group;
    if (cmd.save_g2)   g2_r   <= hash_group;
    if (cmd.save_ev)   evg_r  <= hash_group;
    if (cmd.cap_a) begin
      a0_r <= rowk_r[0];
      a1_r <= rowk_r[1];
    end
    if (cmd.cap_find) begin
      found_r <= found_now;
      fslot_r <= fslot_now;
    end
  end

  // eviction state
  always_ff @(posedge clk) begin
    if (cmd.ev_init) begin
      pend_k_r <= item_r.key;
      pend_v_r <= 64'd0;
      t_r      <= 8'd0;
      odd_r    <= 1'b0;
    end else if (cmd.ev_write) begin
      pend_k_r <= ev_k2;
      pend_v_r <= ev_v2;
      t_r      <= t_r + 8'd1;
      odd_r    <= ~odd_r;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.cnt_dec && (cnt_r != '0)) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result fields by kind
  always_comb begin
    out_nxt              = '0;
    out_nxt.stored_count = 11'(cnt_r);
    case (cmd.res_kind)
      RES_ZERO_KEY: out_nxt.status = STS_ZERO_KEY;
      RES_FIND: begin
        out_nxt.status      = found_r ? STS_OK : STS_MISS;
        out_nxt.result_slot = found_r ? 10'(fslot_r) : 10'd0;
      end
      RES_IDX: begin
        out_nxt.status      = STS_OK;
        out_nxt.result_slot = 10'(idx_slot);
        if (item_r.op == OP_GET) out_nxt.read_value = rowv_r[idx_slot[1:0]];
      end
      RES_INS_OK: begin
        out_nxt.status      = STS_OK;
        out_nxt.result_slot = found_r ? 10'(fslot_r) : 10'd0;
      end
      RES_INS_FAIL: begin
        out_nxt.status        = STS_FAIL;
        out_nxt.ejected_key   = pend_k_r;
        out_nxt.ejected_value = pend_v_r;
      end
      default: out_nxt.status = STS_MISS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status to controller
  assign sts.clr_last     = (clr_addr_r == GROUP_BITS'(ROWS - 1));
  assign sts.hash_done    = hash_done;
  assign sts.found        = found_now;
  assign sts.op           = item_r.op;
  assign sts.key_zero     = (item_r.key == 64'd0);
  assign sts.tries_done   = (t_r >= max_tries_r);
  assign sts.ev_odd       = odd_r;
  assign sts.ev_empty     = (ev_kx == 64'd0);
  assign sts.ev_next_zero = (ev_k2 == 64'd0);
  assign sts.out_busy     = out_valid_r;

endmodule

`default_nettype wire

FILE: design/bcht_ctrl.sv
// ----------------------------------------------------------------------------
// bcht_ctrl
// Operation sequencer: clearing pass, hashing, probes, eviction loop and
// result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bcht_ctrl
  import bcht_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t    state_r, state_nxt;
  res_kind_t kind_r, kind_nxt;
  logic      final_r, final_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      kind_r  <= RES_UNUSED;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      final_r <= final_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    final_nxt    = final_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.rd_src   = RD_G1;
    cmd.res_kind = kind_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        final_nxt = 1'b0;
        case (sts.op)
          OP_LOOKUP, OP_INSERT, OP_DELETE: begin
            if (sts.key_zero) begin
              kind_nxt  = RES_ZERO_KEY;
              state_nxt = ST_RESULT;
            end else begin
              state_nxt = ST_H1;
            end
          end
          OP_SET, OP_GET: state_nxt = ST_IDX_RD;
          default: begin
            kind_nxt  = RES_UNUSED;
            state_nxt = ST_RESULT;
          end
        endcase
      end
      ST_H1: begin
        cmd.hash_start = 1'b1;
        state_nxt      = ST_H1W;
      end
      ST_H1W: begin
        cmd.save_g1 = sts.hash_done;
        if (sts.hash_done) state_nxt = ST_H2;
      end
      ST_H2: begin
        cmd.hash_start = 1'b1;
        cmd.hash_two   = 1'b1;
        state_nxt      = ST_H2W;
      end
      ST_H2W: begin
        cmd.save_g2 = sts.hash_done;
        if (sts.hash_done) state_nxt = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_G1;
        state_nxt  = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_G2;
        cmd.cap_a  = 1'b1;
        state_nxt  = ST_CMP;
      end
      ST_CMP: begin
        cmd.cap_find = 1'b1;
        if (final_r) begin
          kind_nxt  = RES_INS_OK;
          state_nxt = ST_RESULT;
        end else if (sts.op == OP_INSERT) begin
          if (sts.found) begin
            kind_nxt  = RES_INS_OK;
            state_nxt = ST_RESULT;
          end else begin
            cmd.ev_init = 1'b1;
            state_nxt   = ST_EV_CHK;
          end
        end else begin
          kind_nxt  = RES_FIND;
          state_nxt = (sts.op == OP_DELETE && sts.found) ? ST_DEL_WR : ST_RESULT;
        end
      end
      ST_DEL_WR: begin
        cmd.del_write = 1'b1;
        cmd.cnt_dec   = 1'b1;
        state_nxt     = ST_RESULT;
      end
      ST_EV_CHK: begin
        if (sts.tries_done) begin
          kind_nxt  = RES_INS_FAIL;
          state_nxt = ST_RESULT;
        end else begin
          state_nxt = ST_EV_H;
        end
      end
      ST_EV_H: begin
        cmd.hash_start = 1'b1;
        cmd.hash_two   = sts.ev_odd;
        cmd.hash_pend  = 1'b1;
        state_nxt      = ST_EV_HW;
      end
      ST_EV_HW: begin
        cmd.save_ev = sts.hash_done;
        if (sts.hash_done) state_nxt = ST_EV_RD;
      end
      ST_EV_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_EV;
        state_nxt  = ST_EV_WR;
      end
      ST_EV_WR: begin
        cmd.ev_write = 1'b1;
        if (sts.ev_empty || sts.ev_next_zero) begin
          // placed: count it, then probe again for the new key's slot
          cmd.cnt_inc = 1'b1;
          final_nxt   = 1'b1;
          state_nxt   = ST_RD1;
        end else begin
          state_nxt = ST_EV_CHK;
        end
      end
      ST_IDX_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_IDX;
        state_nxt  = ST_IDX_OP;
      end
      ST_IDX_OP: begin
        cmd.set_write = (sts.op == OP_SET);
        kind_nxt      = RES_IDX;
        state_nxt     = ST_RESULT;
      end
      ST_RESULT: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/bucketed_cuckoo_hash_table_unit.sv
// ----------------------------------------------------------------------------
// bucketed_cuckoo_hash_table_unit
// Two-way, two-slot-bucket cuckoo hash table of 64-bit keys and values.
// ----------------------------------------------------------------------------
// After reset the block clears its stores, one row of four slots a cycle
// (256 rows), before it accepts the first item; configuration writes are
// taken at any time. Items are handled one at a time. Each hash runs on
// one shared 32x32 multiplier (three partial products), and every row
// access goes through one registered memory read port. An insert makes up
// to max_tries eviction steps. A finished result waits in an output
// register while the next item is accepted.
`default_nettype none

module bucketed_cuckoo_hash_table_unit
  import bcht_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  bcht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bcht_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: design/bcht_checker.sv
// ----------------------------------------------------------------------------
// bcht_checker
// Port-level checks of the hash table unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bucketed_cuckoo_hash_table_unit_defines.svh"

module bcht_checker
  import bcht_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // a stalled result stays offered
  `BCHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // one item at a time: busy right after an accept
  `BCHT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // failed insert reports no slot
  `BCHT_ASSERT_NOW(a_fail_no_slot, out_valid && out_data.status == STS_FAIL,
                   out_data.result_slot == 10'd0)

  // ejected pair only on a failed insert
  `BCHT_ASSERT_NOW(a_eject_only_fail, out_valid && out_data.status != STS_FAIL,
                   out_data.ejected_key == 64'd0 && out_data.ejected_value == 64'd0)

endmodule

bind bucketed_cuckoo_hash_table_unit bcht_checker u_bcht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
